FILE: rtl/core/hpsf_pkg.sv
// Package for the hex payload sentence framer: header ROM, phase codes, hex helper.
package hpsf_pkg;

  // Header ROM depth and default header length
  localparam int HdrRomSize     = 32;
  localparam int HdrIdxW        = $clog2(HdrRomSize);
  localparam int HeaderLenDef   = 21;

  // Character width on the output side
  localparam int CharW          = 7;

  // Fixed characters of the sentence tail
  localparam logic [CharW-1:0] ChStar = 7'h2A;
  localparam logic [CharW-1:0] ChCr   = 7'h0D;
  localparam logic [CharW-1:0] ChLf   = 7'h0A;

  // Header ROM; entries past the default header hold ASCII zero
  localparam logic [CharW-1:0] HdrRom [HdrRomSize] = '{
    7'h24, 7'h43, 7'h43, 7'h54, 7'h58, 7'h41, 7'h2C, 7'h30,
    7'h33, 7'h31, 7'h34, 7'h31, 7'h34, 7'h37, 7'h2C, 7'h31,
    7'h2C, 7'h32, 7'h2C, 7'h41, 7'h34, 7'h30, 7'h30, 7'h30,
    7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30, 7'h30
  };

  // Emission phase of the sequencer
  typedef enum logic [2:0] {
    PH_HDR,
    PH_HI,
    PH_LO,
    PH_STAR,
    PH_CKH,
    PH_CKL,
    PH_CR,
    PH_LF
  } phase_e;

  // Upper-case ASCII hex digit of a nibble
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + {3'b000, nib};
    end else begin
      ch = 7'h37 + {3'b000, nib};
    end
    return ch;
  endfunction

endpackage

FILE: rtl/core/hex_payload_sentence_framer_unit.sv
// Hex payload sentence framer: header, hex-encoded payload, XOR checksum, CR LF.
// Each payload byte gives two hex characters, loaded one per cycle into the output register
// while the master side accepts; the opening byte first adds the header characters, and the
// closing byte adds the star, two checksum digits, CR and LF.
// A new byte is taken in the cycle the previous byte's last character is loaded.
// Reset (rst_ni low, asynchronous) empties both registers and starts a fresh sentence.
module hex_payload_sentence_framer_unit
  import hpsf_pkg::*;
#(
  parameter int HEADER_LENGTH = HeaderLenDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Slave side: tdata = payload_byte[7:0]; tlast = final_byte
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  // Master side: tdata = sentence_char[6:0], zero[7]; tlast = sentence_end
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,
  output logic       m_axis_tlast_o
);

  // Header length clamped to between one and the ROM depth
  localparam int HdrLen = (HEADER_LENGTH < 1) ? 1 :
                          ((HEADER_LENGTH > HdrRomSize) ? HdrRomSize : HEADER_LENGTH);
  localparam logic [HdrIdxW-1:0] HdrLast = HdrIdxW'(HdrLen - 1);

  // Input beat register and sequencer state
  logic [7:0]         byte_q, byte_d;
  logic               last_q, last_d;
  logic               busy_q, busy_d;
  phase_e             phase_q, phase_d;
  logic [HdrIdxW-1:0] idx_q, idx_d;
  logic               mid_q, mid_d;
  logic [7:0]         xor_q, xor_d;

  // Output register
  logic               ovalid_q, ovalid_d;
  logic [CharW-1:0]   ochar_q, ochar_d;
  logic               oend_q, oend_d;

  logic               emit;
  logic               item_done;
  logic               accept;
  logic [CharW-1:0]   ch;

  // Load a character whenever a beat is held and the output slot frees up
  assign emit      = busy_q && (!ovalid_q || m_axis_tready_i);
  assign item_done = emit && (((phase_q == PH_LO) && !last_q) || (phase_q == PH_LF));
  assign s_axis_tready_o = !busy_q || item_done;
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;

  // Select the character of the current phase
  always_comb begin
    unique case (phase_q)
      PH_HDR:  ch = HdrRom[idx_q];
      PH_HI:   ch = hex_char(byte_q[7:4]);
      PH_LO:   ch = hex_char(byte_q[3:0]);
      PH_STAR: ch = ChStar;
      PH_CKH:  ch = hex_char(xor_q[7:4]);
      PH_CKL:  ch = hex_char(xor_q[3:0]);
      PH_CR:   ch = ChCr;
      PH_LF:   ch = ChLf;
      default: ch = ChLf;
    endcase
  end

  // Next state: advance the sequencer, track checksum and sentence position
  always_comb begin
    byte_d   = byte_q;
    last_d   = last_q;
    busy_d   = busy_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    mid_d    = mid_q;
    xor_d    = xor_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    oend_d   = oend_q;

    if (emit) begin
      ovalid_d = 1'b1;
      ochar_d  = ch;
      oend_d   = (phase_q == PH_LF);
      unique case (phase_q)
        PH_HDR: begin
          mid_d = 1'b1;
          xor_d = (idx_q == '0) ? 8'h00 : (xor_q ^ {1'b0, ch});
          if (idx_q == HdrLast) begin
            phase_d = PH_HI;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        PH_HI: begin
          xor_d   = xor_q ^ {1'b0, ch};
          phase_d = PH_LO;
        end
        PH_LO: begin
          xor_d   = xor_q ^ {1'b0, ch};
          phase_d = PH_STAR;
        end
        PH_STAR: phase_d = PH_CKH;
        PH_CKH:  phase_d = PH_CKL;
        PH_CKL:  phase_d = PH_CR;
        PH_CR:   phase_d = PH_LF;
        PH_LF: begin
          mid_d = 1'b0;
          xor_d = 8'h00;
        end
        default: phase_d = PH_LF;
      endcase
    end else if (m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    if (item_done) begin
      busy_d = 1'b0;
    end

    // Take a new beat; open a header unless a sentence is under way
    if (accept) begin
      byte_d  = s_axis_tdata_i;
      last_d  = s_axis_tlast_i;
      busy_d  = 1'b1;
      idx_d   = '0;
      phase_d = mid_d ? PH_HI : PH_HDR;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      phase_q  <= PH_HDR;
      idx_q    <= '0;
      mid_q    <= 1'b0;
      xor_q    <= 8'h00;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      mid_q    <= mid_d;
      xor_q    <= xor_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    last_q  <= last_d;
    ochar_q <= ochar_d;
    oend_q  <= oend_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {1'b0, ochar_q};
  assign m_axis_tlast_o  = oend_q;

  // A beat is only taken over a held one when that one finishes this cycle
  a_accept_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && busy_q) |-> item_done)
    else $error("new beat accepted while previous beat unfinished");

  // Checksum characters only appear inside an open sentence
  a_cksum_in_sentence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && ((phase_q == PH_CKH) || (phase_q == PH_CKL))) |-> mid_q)
    else $error("checksum emitted outside a sentence");

  // Closing line feed ends the sentence and clears the checksum
  a_lf_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (phase_q == PH_LF)) |=> (!mid_q && (xor_q == 8'h00) && m_axis_tlast_o))
    else $error("sentence not closed after line feed");

endmodule
